/* src/tfn_pkg.sv */
// ----------------------------------------------------------------------------
// tfn_pkg: shared types and constants of the triangle face normal core
// Field widths, pipeline depths and the tag that travels with each triangle.
// ----------------------------------------------------------------------------
package tfn_pkg;

    localparam int POS_W    = 24;   // Q12.12 vertex coordinate
    localparam int EDGE_W   = 25;   // exact edge difference
    localparam int PROD_W   = 50;   // edge product
    localparam int CROSS_W  = 51;   // cross product component, signed
    localparam int MAG_W    = 50;   // cross product magnitude
    localparam int HALF_W   = 25;   // half of a magnitude for the length search
    localparam int HLEN_W   = 5;
    localparam int LEN_W    = 6;
    localparam int TOP_BITS = 30;
    localparam int NRM_W    = 30;   // normalized magnitude
    localparam int SQ_W     = 60;
    localparam int SUM_W    = 62;
    localparam int ROOT_W   = 31;
    localparam int IDX_W    = 16;
    localparam int Q_W      = 15;
    localparam int OUT_W    = 16;   // Q1.14 result
    localparam int UNIT_SHIFT = 14;
    localparam int NUM_W    = 46;   // dividend width
    localparam int DEN_W    = 32;   // divisor width

    localparam int FRONT_STAGES = 8;
    localparam int SQRT_STAGES  = 31;
    localparam int DIV_STAGES   = 15;
    localparam int LATENCY      = FRONT_STAGES + SQRT_STAGES + 1 + DIV_STAGES + 1;

    typedef logic [NRM_W-1:0] mag_t;

    typedef struct packed {
        logic [IDX_W-1:0] idx_a;
        logic [IDX_W-1:0] idx_b;
        logic [IDX_W-1:0] idx_c;
        logic [2:0]       neg;
        logic             degen;
        mag_t             mag_x;
        mag_t             mag_y;
        mag_t             mag_z;
    } side_t;

    // position of the highest set bit plus one, zero for zero
    function automatic logic [HLEN_W-1:0] bit_len(input logic [HALF_W-1:0] v);
        logic [HLEN_W-1:0] n;
        n = '0;
        for (int i = 0; i < HALF_W; i++)
        begin
            if (v[i])
                n = HLEN_W'(i + 1);
        end
        return n;
    endfunction

endpackage

/* src/tfn_isqrt.sv */
// ----------------------------------------------------------------------------
// tfn_isqrt: pipelined integer square root
// One result bit per stage, floor(sqrt(s)) of a 62-bit value.
// ----------------------------------------------------------------------------
module tfn_isqrt
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic [tfn_pkg::SUM_W-1:0]     sum,
    input  tfn_pkg::side_t                in_side,
    output logic                          out_valid,
    output logic [tfn_pkg::ROOT_W-1:0]    root,
    output tfn_pkg::side_t                out_side
);

    localparam int N  = tfn_pkg::SQRT_STAGES;
    localparam int SW = tfn_pkg::SUM_W;

    logic [SW-1:0]  s_reg    [0:N-1];
    logic [SW-1:0]  root_reg [0:N-1];
    logic           vld_reg  [0:N-1];
    tfn_pkg::side_t side_reg [0:N-1];

    genvar g;
    generate
        for (g = 0; g < N; g++)
        begin : g_stage
            localparam int BIT_POS = 2 * (N - 1 - g);
            logic [SW-1:0]  s_in;
            logic [SW-1:0]  r_in;
            logic           v_in;
            tfn_pkg::side_t t_in;
            logic [SW-1:0]  trial;
            logic [SW-1:0]  s_next;
            logic [SW-1:0]  root_next;

            if (g == 0)
            begin : g_first
                assign s_in = sum;
                assign r_in = '0;
                assign v_in = in_valid;
                assign t_in = in_side;
            end
            else
            begin : g_rest
                assign s_in = s_reg[g-1];
                assign r_in = root_reg[g-1];
                assign v_in = vld_reg[g-1];
                assign t_in = side_reg[g-1];
            end

            assign trial = r_in + (SW'(1) << BIT_POS);

            always_comb
            begin
                if (s_in >= trial)
                begin
                    s_next    = s_in - trial;
                    root_next = (r_in >> 1) + (SW'(1) << BIT_POS);
                end
                else
                begin
                    s_next    = s_in;
                    root_next = r_in >> 1;
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    vld_reg[g] <= 1'b0;
                else
                    vld_reg[g] <= v_in;
            end

            always_ff @(posedge clk)
            begin
                s_reg[g]    <= s_next;
                root_reg[g] <= root_next;
                side_reg[g] <= t_in;
            end
        end
    endgenerate

    assign out_valid = vld_reg[N-1];
    assign root      = root_reg[N-1][tfn_pkg::ROOT_W-1:0];
    assign out_side  = side_reg[N-1];

endmodule

/* src/tfn_div.sv */
// ----------------------------------------------------------------------------
// tfn_div: pipelined rounding divider for the three normal components
// q = floor((m * 2^15 + r) / (2r)), one quotient bit per stage per lane.
// ----------------------------------------------------------------------------
module tfn_div
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic [tfn_pkg::ROOT_W-1:0]    root,
    input  tfn_pkg::side_t                in_side,
    output logic                          out_valid,
    output logic [tfn_pkg::Q_W-1:0]       q_x,
    output logic [tfn_pkg::Q_W-1:0]       q_y,
    output logic [tfn_pkg::Q_W-1:0]       q_z,
    output tfn_pkg::side_t                out_side
);

    localparam int N  = tfn_pkg::DIV_STAGES;
    localparam int NW = tfn_pkg::NUM_W;
    localparam int DW = tfn_pkg::DEN_W;
    localparam int QW = tfn_pkg::Q_W;

    logic [NW-1:0]  rem_reg  [0:N][0:2];
    logic [QW-1:0]  q_reg    [0:N][0:2];
    logic [DW-1:0]  den_reg  [0:N];
    logic           vld_reg  [0:N];
    tfn_pkg::side_t side_reg [0:N];

    // dividend and divisor set-up stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg[0] <= 1'b0;
        else
            vld_reg[0] <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        rem_reg[0][0] <= NW'({in_side.mag_x, QW'(0)}) + NW'(root);
        rem_reg[0][1] <= NW'({in_side.mag_y, QW'(0)}) + NW'(root);
        rem_reg[0][2] <= NW'({in_side.mag_z, QW'(0)}) + NW'(root);
        q_reg[0][0]   <= '0;
        q_reg[0][1]   <= '0;
        q_reg[0][2]   <= '0;
        den_reg[0]    <= {root, 1'b0};
        side_reg[0]   <= in_side;
    end

    genvar g, j;
    generate
        for (g = 1; g <= N; g++)
        begin : g_stage
            localparam int SH = N - g;
            logic [NW:0] dsh;

            assign dsh = (NW+1)'(den_reg[g-1]) << SH;

            for (j = 0; j < 3; j++)
            begin : g_lane
                logic [NW-1:0] rem_next;
                logic [QW-1:0] q_next;

                always_comb
                begin
                    if ({1'b0, rem_reg[g-1][j]} >= dsh)
                    begin
                        rem_next = rem_reg[g-1][j] - dsh[NW-1:0];
                        q_next   = q_reg[g-1][j] | (QW'(1) << SH);
                    end
                    else
                    begin
                        rem_next = rem_reg[g-1][j];
                        q_next   = q_reg[g-1][j];
                    end
                end

                always_ff @(posedge clk)
                begin
                    rem_reg[g][j] <= rem_next;
                    q_reg[g][j]   <= q_next;
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    vld_reg[g] <= 1'b0;
                else
                    vld_reg[g] <= vld_reg[g-1];
            end

            always_ff @(posedge clk)
            begin
                den_reg[g]  <= den_reg[g-1];
                side_reg[g] <= side_reg[g-1];
            end
        end
    endgenerate

    assign out_valid = vld_reg[N];
    assign q_x       = q_reg[N][0];
    assign q_y       = q_reg[N][1];
    assign q_z       = q_reg[N][2];
    assign out_side  = side_reg[N];

endmodule

/* src/triangle_face_normal_core.sv */
// throughput: one triangle per cycle, busy is always low
// depth comes mostly from the 31-stage square root and the 15-stage divider
// reset clears only the valid bits, so no stale done appears after reset
// ----------------------------------------------------------------------------
// triangle_face_normal_core: unit face normal of one triangle
// Edges, cross product, common normalization, square root and rounded divide.
// ----------------------------------------------------------------------------
module triangle_face_normal_core
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic signed [tfn_pkg::POS_W-1:0]  a_x,
    input  logic signed [tfn_pkg::POS_W-1:0]  a_y,
    input  logic signed [tfn_pkg::POS_W-1:0]  a_z,
    input  logic signed [tfn_pkg::POS_W-1:0]  b_x,
    input  logic signed [tfn_pkg::POS_W-1:0]  b_y,
    input  logic signed [tfn_pkg::POS_W-1:0]  b_z,
    input  logic signed [tfn_pkg::POS_W-1:0]  c_x,
    input  logic signed [tfn_pkg::POS_W-1:0]  c_y,
    input  logic signed [tfn_pkg::POS_W-1:0]  c_z,
    input  logic [tfn_pkg::IDX_W-1:0]         index_a,
    input  logic [tfn_pkg::IDX_W-1:0]         index_b,
    input  logic [tfn_pkg::IDX_W-1:0]         index_c,
    output logic                              done,
    output logic signed [tfn_pkg::OUT_W-1:0]  normal_x,
    output logic signed [tfn_pkg::OUT_W-1:0]  normal_y,
    output logic signed [tfn_pkg::OUT_W-1:0]  normal_z,
    output logic [tfn_pkg::IDX_W-1:0]         out_index_a,
    output logic [tfn_pkg::IDX_W-1:0]         out_index_b,
    output logic [tfn_pkg::IDX_W-1:0]         out_index_c,
    output logic                              degenerate
);

    localparam int EW = tfn_pkg::EDGE_W;
    localparam int PW = tfn_pkg::PROD_W;
    localparam int CW = tfn_pkg::CROSS_W;
    localparam int MW = tfn_pkg::MAG_W;
    localparam int HW = tfn_pkg::HALF_W;
    localparam int NW = tfn_pkg::NRM_W;
    localparam int OW = tfn_pkg::OUT_W;
    localparam int LW = tfn_pkg::LEN_W;

    assign busy = 1'b0;

    logic accept;
    assign accept = start && !busy;

    // valid bits of the front stages
    logic [tfn_pkg::FRONT_STAGES-1:0] vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= {vld_reg[tfn_pkg::FRONT_STAGES-2:0], accept};
    end

    // stage 1: edges
    logic signed [EW-1:0] ux_reg, uy_reg, uz_reg, vx_reg, vy_reg, vz_reg;
    tfn_pkg::side_t side1_reg;
    tfn_pkg::side_t side_in;

    always_comb
    begin
        side_in       = '0;
        side_in.idx_a = index_a;
        side_in.idx_b = index_b;
        side_in.idx_c = index_c;
    end

    always_ff @(posedge clk)
    begin
        ux_reg    <= EW'(b_x) - EW'(a_x);
        uy_reg    <= EW'(b_y) - EW'(a_y);
        uz_reg    <= EW'(b_z) - EW'(a_z);
        vx_reg    <= EW'(c_x) - EW'(a_x);
        vy_reg    <= EW'(c_y) - EW'(a_y);
        vz_reg    <= EW'(c_z) - EW'(a_z);
        side1_reg <= side_in;
    end

    // stage 2: six products
    logic signed [PW-1:0] p0_reg, p1_reg, p2_reg, p3_reg, p4_reg, p5_reg;
    tfn_pkg::side_t side2_reg;

    always_ff @(posedge clk)
    begin
        p0_reg    <= PW'(uy_reg * vz_reg);
        p1_reg    <= PW'(uz_reg * vy_reg);
        p2_reg    <= PW'(uz_reg * vx_reg);
        p3_reg    <= PW'(ux_reg * vz_reg);
        p4_reg    <= PW'(ux_reg * vy_reg);
        p5_reg    <= PW'(uy_reg * vx_reg);
        side2_reg <= side1_reg;
    end

    // stage 3: cross product, magnitudes and signs
    logic signed [CW-1:0] nx_next, ny_next, nz_next;
    logic [MW-1:0] mx_reg, my_reg, mz_reg;
    tfn_pkg::side_t side3_reg, side3_next;

    always_comb
    begin
        nx_next = CW'(p0_reg) - CW'(p1_reg);
        ny_next = CW'(p2_reg) - CW'(p3_reg);
        nz_next = CW'(p4_reg) - CW'(p5_reg);
        side3_next     = side2_reg;
        side3_next.neg = {nz_next[CW-1], ny_next[CW-1], nx_next[CW-1]};
    end

    always_ff @(posedge clk)
    begin
        mx_reg    <= nx_next[CW-1] ? MW'(-nx_next) : MW'(nx_next);
        my_reg    <= ny_next[CW-1] ? MW'(-ny_next) : MW'(ny_next);
        mz_reg    <= nz_next[CW-1] ? MW'(-nz_next) : MW'(nz_next);
        side3_reg <= side3_next;
    end

    // stage 4: largest magnitude and zero check
    logic [MW-1:0] top_next, top_reg;
    logic [MW-1:0] mx4_reg, my4_reg, mz4_reg;
    tfn_pkg::side_t side4_reg, side4_next;

    always_comb
    begin
        top_next = (mx_reg > my_reg) ? mx_reg : my_reg;
        if (mz_reg > top_next)
            top_next = mz_reg;
        side4_next       = side3_reg;
        side4_next.degen = (mx_reg == '0) && (my_reg == '0) && (mz_reg == '0);
    end

    always_ff @(posedge clk)
    begin
        top_reg   <= top_next;
        mx4_reg   <= mx_reg;
        my4_reg   <= my_reg;
        mz4_reg   <= mz_reg;
        side4_reg <= side4_next;
    end

    // stage 5: bit length search over both halves
    logic [tfn_pkg::HLEN_W-1:0] hi_len_reg, lo_len_reg;
    logic [MW-1:0] mx5_reg, my5_reg, mz5_reg;
    tfn_pkg::side_t side5_reg;

    always_ff @(posedge clk)
    begin
        hi_len_reg <= tfn_pkg::bit_len(top_reg[MW-1:HW]);
        lo_len_reg <= tfn_pkg::bit_len(top_reg[HW-1:0]);
        mx5_reg    <= mx4_reg;
        my5_reg    <= my4_reg;
        mz5_reg    <= mz4_reg;
        side5_reg  <= side4_reg;
    end

    // stage 6: common shift so the largest lands at bit 29
    logic [LW-1:0] len;
    logic          go_right;
    logic [LW-1:0] sh;
    tfn_pkg::side_t side6_reg, side6_next;

    always_comb
    begin
        len = (hi_len_reg != '0) ? LW'(hi_len_reg) + LW'(HW) : LW'(lo_len_reg);
        go_right = len > LW'(tfn_pkg::TOP_BITS);
        sh = go_right ? len - LW'(tfn_pkg::TOP_BITS) : LW'(tfn_pkg::TOP_BITS) - len;
        side6_next = side5_reg;
        if (go_right)
        begin
            side6_next.mag_x = NW'(mx5_reg >> sh);
            side6_next.mag_y = NW'(my5_reg >> sh);
            side6_next.mag_z = NW'(mz5_reg >> sh);
        end
        else
        begin
            side6_next.mag_x = NW'(mx5_reg << sh);
            side6_next.mag_y = NW'(my5_reg << sh);
            side6_next.mag_z = NW'(mz5_reg << sh);
        end
    end

    always_ff @(posedge clk)
    begin
        side6_reg <= side6_next;
    end

    // stage 7: squares
    logic [tfn_pkg::SQ_W-1:0] sqx_reg, sqy_reg, sqz_reg;
    tfn_pkg::side_t side7_reg;

    always_ff @(posedge clk)
    begin
        sqx_reg   <= side6_reg.mag_x * side6_reg.mag_x;
        sqy_reg   <= side6_reg.mag_y * side6_reg.mag_y;
        sqz_reg   <= side6_reg.mag_z * side6_reg.mag_z;
        side7_reg <= side6_reg;
    end

    // stage 8: sum of squares
    logic [tfn_pkg::SUM_W-1:0] sum_reg;
    tfn_pkg::side_t side8_reg;

    always_ff @(posedge clk)
    begin
        sum_reg   <= tfn_pkg::SUM_W'(sqx_reg) + tfn_pkg::SUM_W'(sqy_reg)
                   + tfn_pkg::SUM_W'(sqz_reg);
        side8_reg <= side7_reg;
    end

    logic                         sq_valid;
    logic [tfn_pkg::ROOT_W-1:0]   sq_root;
    tfn_pkg::side_t               sq_side;

    tfn_isqrt u_isqrt
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (vld_reg[tfn_pkg::FRONT_STAGES-1]),
        .sum       (sum_reg),
        .in_side   (side8_reg),
        .out_valid (sq_valid),
        .root      (sq_root),
        .out_side  (sq_side)
    );

    logic                    dv_valid;
    logic [tfn_pkg::Q_W-1:0] qx, qy, qz;
    tfn_pkg::side_t          dv_side;

    tfn_div u_div
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sq_valid),
        .root      (sq_root),
        .in_side   (sq_side),
        .out_valid (dv_valid),
        .q_x       (qx),
        .q_y       (qy),
        .q_z       (qz),
        .out_side  (dv_side)
    );

    // output register: sign and degenerate override
    logic                done_reg;
    logic signed [OW-1:0] nx_reg, ny_reg, nz_reg;
    logic [tfn_pkg::IDX_W-1:0] ia_reg, ib_reg, ic_reg;
    logic                degen_reg;

    function automatic logic [OW-1:0] signed_q(input logic [tfn_pkg::Q_W-1:0] q,
                                               input logic neg, input logic zero);
        logic [OW-1:0] w;
        w = OW'(q);
        if (zero)
            return '0;
        return neg ? -w : w;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= dv_valid;
    end

    always_ff @(posedge clk)
    begin
        nx_reg    <= signed_q(qx, dv_side.neg[0], dv_side.degen);
        ny_reg    <= signed_q(qy, dv_side.neg[1], dv_side.degen);
        nz_reg    <= signed_q(qz, dv_side.neg[2], dv_side.degen);
        ia_reg    <= dv_side.idx_a;
        ib_reg    <= dv_side.idx_b;
        ic_reg    <= dv_side.idx_c;
        degen_reg <= dv_side.degen;
    end

    assign done        = done_reg;
    assign normal_x    = nx_reg;
    assign normal_y    = ny_reg;
    assign normal_z    = nz_reg;
    assign out_index_a = ia_reg;
    assign out_index_b = ib_reg;
    assign out_index_c = ic_reg;
    assign degenerate  = degen_reg;

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, tfn_pkg::LATENCY))
        else $error("result strobe without a matching start");

    a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && degenerate) |-> (normal_x == '0 && normal_y == '0 && normal_z == '0))
        else $error("degenerate result with nonzero normal");

    a_unit_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (normal_x >= -16'sd16384 && normal_x <= 16'sd16384
               && normal_y >= -16'sd16384 && normal_y <= 16'sd16384
               && normal_z >= -16'sd16384 && normal_z <= 16'sd16384))
        else $error("normal component out of unit range");

    a_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !degenerate) |-> (normal_x != '0 || normal_y != '0 || normal_z != '0))
        else $error("zero normal without degenerate flag");

endmodule
